### design/rcwm_pkg.sv
// ----------------------------------------------------------------------------
// rcwm_pkg: runlist cluster mapper shared types and constants
// Field widths, status codes and per-cell data carried along the run chain.
// ----------------------------------------------------------------------------
package rcwm_pkg;

  localparam int unsigned RunEntriesDef = 64;
  localparam int unsigned ShiftMin      = 9;
  localparam int unsigned ShiftMax      = 21;
  localparam logic [4:0]  ShiftReset    = 5'd12;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StUnmapped = 2'd1;
  localparam logic [1:0] StCorrupt  = 2'd2;

  localparam logic [0:0] OpLoad = 1'b0;
  localparam logic [0:0] OpMap  = 1'b1;

  localparam logic [0:0] CfgShift   = 1'b0;
  localparam logic [0:0] CfgPresent = 1'b1;

  // request travelling down the chain
  typedef struct packed {
    logic        busy;
    logic        done;
    logic        ovf;
    logic [63:0] lcn;
    logic [62:0] vcn;
    logic [62:0] prev_vcn;
    logic [63:0] prev_lcn;
    logic        first;
  } rcwm_walk_t;

endpackage

### design/runlist_cluster_write_mapper_unit.sv
// ----------------------------------------------------------------------------
// runlist_cluster_write_mapper_unit: file offset to device offset mapper
// Splits a chunk at the cluster end and looks its cluster up in the runlist.
// ----------------------------------------------------------------------------
// A map word with nonzero remaining is answered after the request moves down
// the chain of run cells one cell a cycle; the Walk state then picks up the
// lookup and the Finish state forms status and offset. One map word is in flight
// at a time and the input stalls until its result word is taken. Load words and
// empty maps give no result. Output is registered.
module runlist_cluster_write_mapper_unit import rcwm_pkg::*; #(
  parameter int unsigned RUN_ENTRIES = RunEntriesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // entry_index, entry_vcn, entry_lcn, entry_length, byte_offset, remaining
  input  logic [263:0] s_axis_tdata,
  // op
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // physical_offset, chunk_length
  output logic [87:0]  m_axis_tdata,
  output logic         m_axis_tlast,
  // status
  output logic [1:0]   m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_index_i,
  input  logic [4:0]   cfg_data_i
);

  localparam int unsigned CntW = $clog2(RUN_ENTRIES + 1);

  typedef enum logic [1:0] {Idle, Walk, Finish, Hold} state_e;

  state_e      state_q;
  logic [4:0]  shift_q;
  logic        present_q;
  logic [CntW-1:0] cnt_q;
  rcwm_walk_t  walk_q;
  rcwm_walk_t  chain [RUN_ENTRIES+1];
  logic [4:0]  sh_q;
  logic [20:0] coff_q;
  logic [21:0] chunk_q;
  logic        last_q;
  logic [87:0] out_q;
  logic        res_last_q;
  logic [1:0]  res_st_q;

  logic        op;
  logic [5:0]  idx;
  logic [62:0] e_vcn, off;
  logic [63:0] e_lcn;
  logic [31:0] e_len, rem;
  logic [4:0]  sh;
  logic [21:0] bpc, coff, chunk;
  logic        acc;
  logic        load_acc;
  logic        cfg_acc;
  rcwm_walk_t  launch;

  assign op    = s_axis_tuser[0];
  assign idx   = s_axis_tdata[5:0];
  assign e_vcn = s_axis_tdata[68:6];
  assign e_lcn = s_axis_tdata[132:69];
  assign e_len = s_axis_tdata[164:133];
  assign off   = s_axis_tdata[227:165];
  assign rem   = s_axis_tdata[259:228];

  assign sh    = (shift_q < 5'(ShiftMin)) ? 5'(ShiftMin) :
                 (shift_q > 5'(ShiftMax)) ? 5'(ShiftMax) : shift_q;
  assign bpc   = 22'd1 << sh;
  assign coff  = off[21:0] & (bpc - 22'd1);
  assign chunk = ({10'd0, bpc - coff} > rem) ? rem[21:0] : bpc - coff;

  assign s_axis_tready = (state_q == Idle);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign load_acc      = acc && (op == OpLoad);
  assign cfg_ready_o   = (state_q == Idle);
  assign cfg_acc       = cfg_valid_i && cfg_ready_o;
  assign m_axis_tvalid = (state_q == Hold);
  assign m_axis_tdata  = out_q;
  assign m_axis_tlast  = res_last_q;
  assign m_axis_tuser  = res_st_q;

  always_comb begin
    launch       = '0;
    launch.busy  = 1'b1;
    launch.first = 1'b1;
    launch.vcn   = off >> sh;
  end

  assign chain[0] = walk_q;

  for (genvar g = 0; g < RUN_ENTRIES; g++) begin : g_cell
    rcwm_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_i      (load_acc && (32'(idx) == 32'(g))),
      .wr_vcn_i  (e_vcn),
      .wr_lcn_i  (e_lcn),
      .wr_nz_i   (e_len != 32'd0),
      .is_last_i (g == RUN_ENTRIES - 1),
      .walk_i    (chain[g]),
      .walk_o    (chain[g+1])
    );
  end

  rcwm_walk_t cur;

  always_comb begin
    cur = chain[RUN_ENTRIES];
  end

  logic [63:0] lcn_f, p;
  logic [1:0]  st;
  logic [63:0] lim;
  assign lcn_f = walk_q.lcn;
  assign lim   = 64'hFFFF_FFFF_FFFF_FFFF >> sh_q;
  assign p     = lcn_f << sh_q;

  always_comb begin
    st = StOk;
    if (!present_q) st = StUnmapped;
    else if (walk_q.ovf) st = StCorrupt;
    else if (lcn_f == -64'sd1 || lcn_f == -64'sd2 || lcn_f == -64'sd3) st = StUnmapped;
    else if (lcn_f[63]) st = StCorrupt;
    else if (lcn_f > lim) st = StCorrupt;
    else if (p > ~{43'd0, coff_q}) st = StCorrupt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= Idle;
      shift_q    <= ShiftReset;
      present_q  <= 1'b0;
      cnt_q      <= '0;
      walk_q     <= '0;
      sh_q       <= '0;
      coff_q     <= '0;
      chunk_q    <= '0;
      last_q     <= 1'b0;
      out_q      <= '0;
      res_last_q <= 1'b0;
      res_st_q   <= StOk;
    end else begin
      if (cfg_acc) begin
        if (cfg_index_i == CfgShift) shift_q <= cfg_data_i;
        else present_q <= cfg_data_i[0];
      end
      case (state_q)
        Idle: begin
          if (acc && op == OpMap && rem != 32'd0) begin
            walk_q  <= launch;
            sh_q    <= sh;
            coff_q  <= coff[20:0];
            chunk_q <= chunk;
            last_q  <= {10'd0, chunk} == rem;
            cnt_q   <= '0;
            state_q <= Walk;
          end
        end
        Walk: begin
          if (cnt_q == CntW'(RUN_ENTRIES)) begin
            walk_q  <= cur;
            state_q <= Finish;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        Finish: begin
          out_q      <= {2'd0, chunk_q, (st == StOk) ? p + {43'd0, coff_q} : 64'd0};
          res_last_q <= last_q;
          res_st_q   <= st;
          state_q    <= Hold;
        end
        Hold: begin
          if (m_axis_tready) state_q <= Idle;
        end
        default: state_q <= Idle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Finish) |=> m_axis_tvalid) else $error("result not shown");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Walk && cnt_q == CntW'(RUN_ENTRIES)) |-> cur.done)
    else $error("walk did not finish");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
       $stable(m_axis_tlast)))
    else $error("result word changed while waiting");

endmodule

### design/rcwm_cell.sv
// ----------------------------------------------------------------------------
// rcwm_cell: one runlist entry and one scan step
// Holds one run, decides one step of the walk and registers it for the next cell.
// ----------------------------------------------------------------------------
module rcwm_cell import rcwm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_i,
  input  logic [62:0] wr_vcn_i,
  input  logic [63:0] wr_lcn_i,
  input  logic        wr_nz_i,
  input  logic        is_last_i,
  input  rcwm_walk_t  walk_i,
  output rcwm_walk_t  walk_o
);

  logic [62:0] vcn_q;
  logic [63:0] lcn_q;
  logic        nz_q;
  logic [63:0] delta;
  logic [64:0] sum;
  rcwm_walk_t  walk_d;
  rcwm_walk_t  walk_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      vcn_q <= wr_vcn_i;
      lcn_q <= wr_lcn_i;
      nz_q  <= wr_nz_i;
    end
  end

  assign delta = {1'b0, walk_i.vcn} - {1'b0, walk_i.prev_vcn};
  assign sum   = {walk_i.prev_lcn[63], walk_i.prev_lcn} + {delta[63], delta};

  always_comb begin
    walk_d = walk_i;
    walk_d.first    = 1'b0;
    walk_d.prev_vcn = vcn_q;
    walk_d.prev_lcn = lcn_q;
    if (walk_i.busy && !walk_i.done) begin
      if (walk_i.first) begin
        if (walk_i.vcn < vcn_q) begin
          walk_d.done = 1'b1;
          walk_d.lcn  = -64'sd3;
        end
      end else if (walk_i.vcn < vcn_q) begin
        walk_d.done = 1'b1;
        if (walk_i.prev_lcn[63]) begin
          walk_d.lcn = walk_i.prev_lcn;
        end else if (sum[64] != sum[63]) begin
          walk_d.ovf = 1'b1;
        end else begin
          walk_d.lcn = sum[63:0];
        end
      end
      if (!walk_d.done && !nz_q) begin
        walk_d.done = 1'b1;
        walk_d.lcn  = lcn_q[63] ? lcn_q : -64'sd3;
      end else if (!walk_d.done && is_last_i) begin
        walk_d.done = 1'b1;
        walk_d.lcn  = -64'sd3;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q <= '0;
    end else begin
      walk_q <= walk_d;
    end
  end

  assign walk_o = walk_q;

endmodule
